FILE: rtl/tarc_pkg.sv
`default_nettype none

package tarc_pkg;

    localparam int SAMPLES_AVERAGED = 5;
    localparam int TOTAL_READS      = 2 + 2 * SAMPLES_AVERAGED;
    localparam int READ_W           = $clog2(TOTAL_READS);
    localparam int SAMPLE_W         = 12;
    localparam int SPAN_W           = 10;
    localparam int SUM_W            = SAMPLE_W + $clog2(SAMPLES_AVERAGED + 1);
    localparam int PROD_W           = SAMPLE_W + SPAN_W;
    localparam int DIV_W            = PROD_W;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 12;
    localparam int PC_W             = 4;

    // sum / SAMPLES_AVERAGED as multiply by rounded-up reciprocal, exact for any sum
    localparam int RECIP_W          = SUM_W + 1;
    localparam int AVG_SHIFT        = SUM_W + $clog2(SAMPLES_AVERAGED);
    localparam int AVG_PROD_W       = SUM_W + RECIP_W;
    localparam logic [63:0] AVG_SCALE = 64'd1 << AVG_SHIFT;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((AVG_SCALE + 64'(SAMPLES_AVERAGED - 1)) / 64'(SAMPLES_AVERAGED));

    localparam logic [7:0] CMD_X  = 8'hD0;
    localparam logic [7:0] CMD_Y  = 8'h90;
    localparam logic [7:0] CMD_Z1 = 8'hB0;
    localparam logic [7:0] CMD_Z2 = 8'hC0;

    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 12'd50;
    localparam logic [SAMPLE_W-1:0] RST_X_MIN     = 12'd460;
    localparam logic [SAMPLE_W-1:0] RST_X_MAX     = 12'd1730;
    localparam logic [SAMPLE_W-1:0] RST_Y_MIN     = 12'd265;
    localparam logic [SAMPLE_W-1:0] RST_Y_MAX     = 12'd1680;
    localparam logic [SPAN_W-1:0]   RST_X_SPAN    = 10'd239;
    localparam logic [SPAN_W-1:0]   RST_Y_SPAN    = 10'd319;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD,
        REG_X_MIN,
        REG_X_MAX,
        REG_Y_MIN,
        REG_Y_MAX,
        REG_X_SPAN,
        REG_Y_SPAN
    } cfg_reg_t;

    typedef enum logic {
        ACT_START,
        ACT_XFER
    } action_t;

    typedef enum logic {
        KIND_TX,
        KIND_REPORT
    } kind_t;

    typedef enum logic [1:0] {
        ST_TOUCH,
        ST_NO_TOUCH,
        ST_OUTSIDE,
        ST_FAIL
    } status_t;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_DSTART,
        OP_DWAIT,
        OP_CLASSIFY,
        OP_MUL,
        OP_EMIT,
        OP_AVERAGE
    } op_t;

    typedef enum logic [1:0] {
        SEL_AVG_X,
        SEL_AVG_Y,
        SEL_COORD_X,
        SEL_COORD_Y
    } sel_t;

    typedef struct packed {
        op_t             op;
        sel_t            sel;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic reading_done;
        logic div_busy;
        logic not_touch;
        logic out_blocked;
    } cond_t;

    localparam logic [PC_W-1:0] PC_WAIT = PC_W'(0);
    localparam logic [PC_W-1:0] PC_EMIT = PC_W'(10);

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '{op: OP_WAIT, sel: SEL_AVG_X, target: PC_WAIT};
        case (pc)
            PC_W'(0):  c = '{op: OP_WAIT,     sel: SEL_AVG_X,   target: PC_W'(1)};
            PC_W'(1):  c = '{op: OP_AVERAGE,  sel: SEL_AVG_X,   target: PC_WAIT};
            PC_W'(2):  c = '{op: OP_AVERAGE,  sel: SEL_AVG_Y,   target: PC_WAIT};
            PC_W'(3):  c = '{op: OP_CLASSIFY, sel: SEL_AVG_X,   target: PC_EMIT};
            PC_W'(4):  c = '{op: OP_MUL,      sel: SEL_COORD_X, target: PC_WAIT};
            PC_W'(5):  c = '{op: OP_DSTART,   sel: SEL_COORD_X, target: PC_WAIT};
            PC_W'(6):  c = '{op: OP_DWAIT,    sel: SEL_COORD_X, target: PC_WAIT};
            PC_W'(7):  c = '{op: OP_MUL,      sel: SEL_COORD_Y, target: PC_WAIT};
            PC_W'(8):  c = '{op: OP_DSTART,   sel: SEL_COORD_Y, target: PC_WAIT};
            PC_W'(9):  c = '{op: OP_DWAIT,    sel: SEL_COORD_Y, target: PC_WAIT};
            PC_W'(10): c = '{op: OP_EMIT,     sel: SEL_AVG_X,   target: PC_WAIT};
            default:   c = '{op: OP_WAIT,     sel: SEL_AVG_X,   target: PC_W'(1)};
        endcase
        return c;
    endfunction

    function automatic logic [7:0] command_for(input logic [READ_W-1:0] r);
        logic [7:0] cmd;
        if (r == READ_W'(0)) begin
            cmd = CMD_Z1;
        end else if (r == READ_W'(1)) begin
            cmd = CMD_Z2;
        end else if (r < READ_W'(2 + SAMPLES_AVERAGED)) begin
            cmd = CMD_X;
        end else begin
            cmd = CMD_Y;
        end
        return cmd;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tarc_ifs.sv
`default_nettype none

interface tarc_item_if
    import tarc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;
    logic       transfer_failed;

    modport source (output valid, action, rx_byte, transfer_failed, input ready);
    modport sink   (input valid, action, rx_byte, transfer_failed, output ready);
endinterface

interface tarc_result_if
    import tarc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [7:0]          tx_byte;
    logic [1:0]          status;
    logic [SPAN_W-1:0]   screen_x;
    logic [SPAN_W-1:0]   screen_y;
    logic [SAMPLE_W-1:0] raw_x;
    logic [SAMPLE_W-1:0] raw_y;
    logic [SAMPLE_W-1:0] raw_z1;
    logic [SAMPLE_W-1:0] raw_z2;

    modport source (output valid, kind, tx_byte, status, screen_x, screen_y,
                    raw_x, raw_y, raw_z1, raw_z2, input ready);
    modport sink   (input valid, kind, tx_byte, status, screen_x, screen_y,
                    raw_x, raw_y, raw_z1, raw_z2, output ready);
endinterface

`default_nettype wire

FILE: rtl/tarc_divider.sv
`default_nettype none

module tarc_divider
    import tarc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DIV_W-1:0]    dividend,
    input  wire logic [SAMPLE_W-1:0] divisor,
    output logic                     busy,
    output logic [DIV_W-1:0]         quotient
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [SAMPLE_W-1:0] dvsr_reg, dvsr_next;
    logic [SAMPLE_W:0]   rem_shift;
    logic [SAMPLE_W:0]   diff;
    logic                fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        diff      = rem_shift - {1'b0, dvsr_reg};
        fits      = !diff[SAMPLE_W];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle
            rem_next  = fits ? diff[SAMPLE_W-1:0] : rem_shift[SAMPLE_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvsr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvsr_reg <= dvsr_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/tarc_sequencer.sv
`default_nettype none

module tarc_sequencer
    import tarc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cond_t cond,
    output ctrl_t      ctrl
);
    logic [PC_W-1:0] pc_reg, pc_next;

    assign ctrl = ucode(pc_reg);

    always_comb
    begin
        pc_next = pc_reg + PC_W'(1);
        case (ctrl.op)
            OP_WAIT:     pc_next = cond.reading_done ? ctrl.target : pc_reg;
            OP_DWAIT:    pc_next = cond.div_busy ? pc_reg : pc_reg + PC_W'(1);
            OP_CLASSIFY: pc_next = cond.not_touch ? ctrl.target : pc_reg + PC_W'(1);
            OP_EMIT:     pc_next = cond.out_blocked ? pc_reg : ctrl.target;
            default:     pc_next = pc_reg + PC_W'(1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/touch_adc_read_average_calibrate.sv
// Byte words: the next byte to send appears the cycle after the word is taken.
// Last byte of a reading: the report follows averaging, classification and,
// for a touch only, two scaling divisions. One word in flight.
// Averages come from a reciprocal multiply; screen scaling uses the restoring
// divider (one quotient bit per cycle; two divisions for a touch, else none).
// Reset (rst_n low, asynchronous): idle, registers at their default calibration.
`default_nettype none

module touch_adc_read_average_calibrate
    import tarc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tarc_item_if.sink                  item,
    tarc_result_if.source              result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    ctrl_t ctrl;
    cond_t cond;

    logic [SAMPLE_W-1:0] thr_reg, xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic [SPAN_W-1:0]   xspan_reg, yspan_reg;

    logic                busy_reg, busy_next;
    logic [READ_W-1:0]   read_reg, read_next;
    logic [1:0]          byte_reg, byte_next;
    logic [7:0]          high_reg, high_next;
    logic [SUM_W-1:0]    sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]    sum_y_reg, sum_y_next;
    logic [SAMPLE_W-1:0] z1_reg, z1_next;
    logic [SAMPLE_W-1:0] z2_reg, z2_next;
    logic [SAMPLE_W-1:0] x_avg_reg, x_avg_next;
    logic [SAMPLE_W-1:0] y_avg_reg, y_avg_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SPAN_W-1:0]   sx_reg, sx_next;
    logic [SPAN_W-1:0]   sy_reg, sy_next;
    logic [1:0]          status_reg, status_next;
    logic                div_zero_reg, div_zero_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [7:0]          out_tx_reg, out_tx_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [SPAN_W-1:0]   out_sx_reg, out_sx_next;
    logic [SPAN_W-1:0]   out_sy_reg, out_sy_next;
    logic [SAMPLE_W-1:0] out_x_reg, out_x_next;
    logic [SAMPLE_W-1:0] out_y_reg, out_y_next;
    logic [SAMPLE_W-1:0] out_z1_reg, out_z1_next;
    logic [SAMPLE_W-1:0] out_z2_reg, out_z2_next;

    logic                  out_free;
    logic                  in_acc;
    logic [15:0]           word;
    logic [SAMPLE_W-1:0]   sample;
    logic [1:0]            class_status;
    logic                  emit_tx, emit_fail, emit_report;
    logic [7:0]            emit_byte;
    logic                  done;
    logic                  div_start, div_busy;
    logic [DIV_W-1:0]      dividend, quotient;
    logic [SAMPLE_W-1:0]   divisor;
    logic [SAMPLE_W-1:0]   mul_a;
    logic [SPAN_W-1:0]     mul_b;
    logic [AVG_PROD_W-1:0] avg_prod;

    assign out_free   = !out_valid_reg || result.ready;
    assign item.ready = (ctrl.op == OP_WAIT) && out_free;
    assign in_acc     = item.valid && item.ready;
    assign word       = {high_reg, item.rx_byte};
    assign sample     = word[15:4];

    always_comb
    begin
        if (z1_reg < thr_reg)
        begin
            class_status = ST_NO_TOUCH;
        end
        else if (x_avg_reg < xmin_reg || x_avg_reg > xmax_reg ||
                 y_avg_reg < ymin_reg || y_avg_reg > ymax_reg)
        begin
            class_status = ST_OUTSIDE;
        end
        else
        begin
            class_status = ST_TOUCH;
        end
    end

    tarc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    tarc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign cond.reading_done = done;
    assign cond.div_busy     = div_busy;
    assign cond.not_touch    = (class_status != ST_TOUCH);
    assign cond.out_blocked  = !out_free;

    always_comb
    begin
        busy_next     = busy_reg;
        read_next     = read_reg;
        byte_next     = byte_reg;
        high_next     = high_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        z1_next       = z1_reg;
        z2_next       = z2_reg;
        x_avg_next    = x_avg_reg;
        y_avg_next    = y_avg_reg;
        prod_next     = prod_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        status_next   = status_reg;
        emit_tx       = 1'b0;
        emit_fail     = 1'b0;
        emit_report   = 1'b0;
        emit_byte     = 8'd0;
        done          = 1'b0;
        div_start     = 1'b0;
        dividend      = '0;
        divisor       = '0;
        mul_a         = '0;
        mul_b         = '0;
        avg_prod      = '0;

        case (ctrl.op)
            OP_WAIT:
            begin
                if (in_acc)
                begin
                    if (item.action == ACT_START)
                    begin
                        busy_next  = 1'b1;
                        read_next  = '0;
                        byte_next  = 2'd0;
                        high_next  = 8'd0;
                        sum_x_next = '0;
                        sum_y_next = '0;
                        z1_next    = '0;
                        z2_next    = '0;
                        emit_tx    = 1'b1;
                        emit_byte  = command_for(READ_W'(0));
                    end
                    else if (busy_reg)
                    begin
                        if (item.transfer_failed)
                        begin
                            busy_next = 1'b0;
                            read_next = '0;
                            byte_next = 2'd0;
                            emit_fail = 1'b1;
                        end
                        else if (byte_reg == 2'd0)
                        begin
                            byte_next = 2'd1;
                            emit_tx   = 1'b1;
                        end
                        else if (byte_reg == 2'd1)
                        begin
                            high_next = item.rx_byte;
                            byte_next = 2'd2;
                            emit_tx   = 1'b1;
                        end
                        else
                        begin
                            byte_next = 2'd0;
                            if (read_reg == READ_W'(0))
                            begin
                                z1_next = sample;
                            end
                            else if (read_reg == READ_W'(1))
                            begin
                                z2_next = sample;
                            end
                            else if (read_reg < READ_W'(2 + SAMPLES_AVERAGED))
                            begin
                                sum_x_next = sum_x_reg + SUM_W'(sample);
                            end
                            else
                            begin
                                sum_y_next = sum_y_reg + SUM_W'(sample);
                            end
                            if (read_reg == READ_W'(TOTAL_READS - 1))
                            begin
                                busy_next = 1'b0;
                                read_next = '0;
                                done      = 1'b1;
                            end
                            else
                            begin
                                read_next = read_reg + READ_W'(1);
                                emit_tx   = 1'b1;
                                emit_byte = command_for(read_reg + READ_W'(1));
                            end
                        end
                    end
                end
            end
            OP_AVERAGE:
            begin
                if (ctrl.sel == SEL_AVG_Y)
                begin
                    avg_prod   = AVG_PROD_W'(sum_y_reg) * AVG_PROD_W'(AVG_RECIP);
                    y_avg_next = avg_prod[AVG_SHIFT +: SAMPLE_W];
                end
                else
                begin
                    avg_prod   = AVG_PROD_W'(sum_x_reg) * AVG_PROD_W'(AVG_RECIP);
                    x_avg_next = avg_prod[AVG_SHIFT +: SAMPLE_W];
                end
            end
            OP_DSTART:
            begin
                div_start = 1'b1;
                case (ctrl.sel)
                    SEL_COORD_X:
                    begin
                        dividend = prod_reg;
                        divisor  = xmax_reg - xmin_reg;
                    end
                    SEL_COORD_Y:
                    begin
                        dividend = prod_reg;
                        divisor  = ymax_reg - ymin_reg;
                    end
                    default:
                    begin
                        dividend = '0;
                        divisor  = '0;
                    end
                endcase
            end
            OP_DWAIT:
            begin
                if (!div_busy)
                begin
                    case (ctrl.sel)
                        SEL_COORD_X: sx_next = div_zero_reg ? '0 : quotient[SPAN_W-1:0];
                        SEL_COORD_Y: sy_next = div_zero_reg ? '0 : quotient[SPAN_W-1:0];
                        default:     ;
                    endcase
                end
            end
            OP_CLASSIFY:
            begin
                status_next = class_status;
                sx_next     = '0;
                sy_next     = '0;
            end
            OP_MUL:
            begin
                if (ctrl.sel == SEL_COORD_Y)
                begin
                    mul_a = ymax_reg - y_avg_reg;
                    mul_b = yspan_reg;
                end
                else
                begin
                    mul_a = x_avg_reg - xmin_reg;
                    mul_b = xspan_reg;
                end
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            OP_EMIT:
            begin
                emit_report = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign div_zero_next = div_start ? (divisor == '0) : div_zero_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !result.ready;
        out_kind_next   = out_kind_reg;
        out_tx_next     = out_tx_reg;
        out_status_next = out_status_reg;
        out_sx_next     = out_sx_reg;
        out_sy_next     = out_sy_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_z1_next     = out_z1_reg;
        out_z2_next     = out_z2_reg;
        if (emit_tx || emit_fail || emit_report)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = emit_tx ? KIND_TX : KIND_REPORT;
            out_tx_next     = emit_tx ? emit_byte : 8'd0;
            out_status_next = emit_fail ? ST_FAIL : (emit_report ? status_reg : ST_TOUCH);
            out_sx_next     = emit_report ? sx_reg : '0;
            out_sy_next     = emit_report ? sy_reg : '0;
            out_x_next      = emit_report ? x_avg_reg : '0;
            out_y_next      = emit_report ? y_avg_reg : '0;
            out_z1_next     = emit_report ? z1_reg : '0;
            out_z2_next     = emit_report ? z2_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= RST_THRESHOLD;
            xmin_reg  <= RST_X_MIN;
            xmax_reg  <= RST_X_MAX;
            ymin_reg  <= RST_Y_MIN;
            ymax_reg  <= RST_Y_MAX;
            xspan_reg <= RST_X_SPAN;
            yspan_reg <= RST_Y_SPAN;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: thr_reg   <= cfg_data;
                REG_X_MIN:     xmin_reg  <= cfg_data;
                REG_X_MAX:     xmax_reg  <= cfg_data;
                REG_Y_MIN:     ymin_reg  <= cfg_data;
                REG_Y_MAX:     ymax_reg  <= cfg_data;
                REG_X_SPAN:    xspan_reg <= cfg_data[SPAN_W-1:0];
                REG_Y_SPAN:    yspan_reg <= cfg_data[SPAN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            read_reg       <= '0;
            byte_reg       <= 2'd0;
            high_reg       <= 8'd0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            z1_reg         <= '0;
            z2_reg         <= '0;
            x_avg_reg      <= '0;
            y_avg_reg      <= '0;
            prod_reg       <= '0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            status_reg     <= ST_TOUCH;
            div_zero_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_TX;
            out_tx_reg     <= 8'd0;
            out_status_reg <= ST_TOUCH;
            out_sx_reg     <= '0;
            out_sy_reg     <= '0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_z1_reg     <= '0;
            out_z2_reg     <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            read_reg       <= read_next;
            byte_reg       <= byte_next;
            high_reg       <= high_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            z1_reg         <= z1_next;
            z2_reg         <= z2_next;
            x_avg_reg      <= x_avg_next;
            y_avg_reg      <= y_avg_next;
            prod_reg       <= prod_next;
            sx_reg         <= sx_next;
            sy_reg         <= sy_next;
            status_reg     <= status_next;
            div_zero_reg   <= div_zero_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_tx_reg     <= out_tx_next;
            out_status_reg <= out_status_next;
            out_sx_reg     <= out_sx_next;
            out_sy_reg     <= out_sy_next;
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            out_z1_reg     <= out_z1_next;
            out_z2_reg     <= out_z2_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.kind     = out_kind_reg;
    assign result.tx_byte  = out_tx_reg;
    assign result.status   = out_status_reg;
    assign result.screen_x = out_sx_reg;
    assign result.screen_y = out_sy_reg;
    assign result.raw_x    = out_x_reg;
    assign result.raw_y    = out_y_reg;
    assign result.raw_z1   = out_z1_reg;
    assign result.raw_z2   = out_z2_reg;

endmodule

`default_nettype wire

FILE: rtl/tarc_checker.sv
`default_nettype none

module tarc_checker
    import tarc_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_ready,
    input wire logic                item_action,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire logic                kind,
    input wire logic [7:0]          tx_byte,
    input wire logic [1:0]          status,
    input wire logic [SPAN_W-1:0]   screen_x,
    input wire logic [SPAN_W-1:0]   screen_y,
    input wire logic [SAMPLE_W-1:0] raw_x,
    input wire logic [SAMPLE_W-1:0] raw_y,
    input wire logic [SAMPLE_W-1:0] raw_z1,
    input wire logic [SAMPLE_W-1:0] raw_z2
);
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid &&
            $stable({kind, tx_byte, status, screen_x, screen_y, raw_x, raw_y, raw_z1, raw_z2}))
        else $error("result word changed while stalled");

    a_start_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_action == ACT_START |=>
            result_valid && kind == KIND_TX && tx_byte == CMD_Z1)
        else $error("start not answered with the Z1 command");

    a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_TX |-> status == ST_TOUCH &&
            screen_x == '0 && screen_y == '0 && raw_x == '0 && raw_y == '0 &&
            raw_z1 == '0 && raw_z2 == '0)
        else $error("byte word carries report fields");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_REPORT && status == ST_FAIL |->
            tx_byte == 8'd0 && screen_x == '0 && screen_y == '0 && raw_x == '0 &&
            raw_y == '0 && raw_z1 == '0 && raw_z2 == '0)
        else $error("failure report with nonzero values");

    a_nontouch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_REPORT && status != ST_TOUCH |->
            screen_x == '0 && screen_y == '0)
        else $error("screen point set without a touch");

endmodule

bind touch_adc_read_average_calibrate tarc_checker u_tarc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_action  (item.action),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .kind         (result.kind),
    .tx_byte      (result.tx_byte),
    .status       (result.status),
    .screen_x     (result.screen_x),
    .screen_y     (result.screen_y),
    .raw_x        (result.raw_x),
    .raw_y        (result.raw_y),
    .raw_z1       (result.raw_z1),
    .raw_z2       (result.raw_z2)
);

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import tarc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
    localparam logic [7:0] FILL_BYTE = 8'h00;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 150;
    localparam int READINGS_PER_SETTING = 4;

    typedef struct packed {
        kind_t               kind;
        logic [7:0]          tx_byte;
        status_t             status;
        logic [SPAN_W-1:0]   screen_x;
        logic [SPAN_W-1:0]   screen_y;
        logic [SAMPLE_W-1:0] raw_x;
        logic [SAMPLE_W-1:0] raw_y;
        logic [SAMPLE_W-1:0] raw_z1;
        logic [SAMPLE_W-1:0] raw_z2;
    } touch_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tarc_item_if   item_bus ();
    tarc_result_if result_bus ();

    touch_adc_read_average_calibrate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [SAMPLE_W-1:0] cal_threshold = RST_THRESHOLD;
    logic [SAMPLE_W-1:0] cal_x_min     = RST_X_MIN;
    logic [SAMPLE_W-1:0] cal_x_max     = RST_X_MAX;
    logic [SAMPLE_W-1:0] cal_y_min     = RST_Y_MIN;
    logic [SAMPLE_W-1:0] cal_y_max     = RST_Y_MAX;
    logic [SPAN_W-1:0]   cal_x_span    = RST_X_SPAN;
    logic [SPAN_W-1:0]   cal_y_span    = RST_Y_SPAN;

    bit                  reading_active;
    int                  read_count;
    int                  byte_count;
    logic [7:0]          msb_byte;
    int                  sample_total;
    logic [SAMPLE_W-1:0] z1_sample;
    logic [SAMPLE_W-1:0] z2_sample;
    logic [SAMPLE_W-1:0] x_mean;

    touch_word_t expected_words[$];
    int          mismatches;
    bit          steady;
    int          idle_cycles;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] command_at(input int r);
        if (r == 0) return CMD_Z1;
        if (r == 1) return CMD_Z2;
        if (r < 2 + SAMPLES_AVERAGED) return CMD_X;
        return CMD_Y;
    endfunction

    function automatic touch_word_t byte_word(input logic [7:0] b);
        touch_word_t w;
        w = '0;
        w.kind = KIND_TX;
        w.tx_byte = b;
        return w;
    endfunction

    function automatic touch_word_t report_word(input logic [SAMPLE_W-1:0] x, y);
        touch_word_t w;
        int dx;
        int dy;
        w = '0;
        w.kind = KIND_REPORT;
        w.raw_x = x;
        w.raw_y = y;
        w.raw_z1 = z1_sample;
        w.raw_z2 = z2_sample;
        if (z1_sample < cal_threshold) begin
            w.status = ST_NO_TOUCH;
        end else if (x < cal_x_min || x > cal_x_max || y < cal_y_min || y > cal_y_max) begin
            w.status = ST_OUTSIDE;
        end else begin
            w.status = ST_TOUCH;
            dx = int'(cal_x_max) - int'(cal_x_min);
            dy = int'(cal_y_max) - int'(cal_y_min);
            if (dx != 0)
                w.screen_x = SPAN_W'((int'(x) - int'(cal_x_min)) * int'(cal_x_span) / dx);
            if (dy != 0)
                w.screen_y = SPAN_W'((int'(cal_y_max) - int'(y)) * int'(cal_y_span) / dy);
        end
        return w;
    endfunction

    function automatic void advance_reader(input logic act, input logic [7:0] rx,
                                           input logic fail);
        logic [SAMPLE_W-1:0] smp;
        touch_word_t         w;
        if (act == ACT_START) begin
            reading_active = 1'b1;
            read_count = 0;
            byte_count = 0;
            msb_byte = '0;
            sample_total = 0;
            z1_sample = '0;
            z2_sample = '0;
            x_mean = '0;
            expected_words.push_back(byte_word(command_at(0)));
        end else if (!reading_active) begin
            // transfer while idle: dropped
        end else if (fail) begin
            reading_active = 1'b0;
            read_count = 0;
            byte_count = 0;
            sample_total = 0;
            w = '0;
            w.kind = KIND_REPORT;
            w.status = ST_FAIL;
            expected_words.push_back(w);
        end else if (byte_count == 0) begin
            byte_count = 1;
            expected_words.push_back(byte_word(FILL_BYTE));
        end else if (byte_count == 1) begin
            msb_byte = rx;
            byte_count = 2;
            expected_words.push_back(byte_word(FILL_BYTE));
        end else begin
            smp = SAMPLE_W'({msb_byte, rx} >> 4);
            byte_count = 0;
            if (read_count == 0) begin
                z1_sample = smp;
            end else if (read_count == 1) begin
                z2_sample = smp;
            end else begin
                sample_total += int'(smp);
                if (read_count == 1 + SAMPLES_AVERAGED) begin
                    x_mean = SAMPLE_W'(sample_total / SAMPLES_AVERAGED);
                    sample_total = 0;
                end
            end
            read_count++;
            if (read_count >= TOTAL_READS) begin
                reading_active = 1'b0;
                read_count = 0;
                expected_words.push_back(
                    report_word(x_mean, SAMPLE_W'(sample_total / SAMPLES_AVERAGED)));
                sample_total = 0;
            end else begin
                expected_words.push_back(byte_word(command_at(read_count)));
            end
        end
    endfunction

    function automatic string word_text(input touch_word_t w);
        return $sformatf("kind=%0d tx=%02h st=%0d sx=%0d sy=%0d x=%0d y=%0d z1=%0d z2=%0d",
                         w.kind, w.tx_byte, w.status, w.screen_x, w.screen_y,
                         w.raw_x, w.raw_y, w.raw_z1, w.raw_z2);
    endfunction

    function automatic void flag_mismatch(input string what, input touch_word_t want, got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected %s, got %s", $time, what, word_text(want), word_text(got));
    endfunction

    function automatic int draw_wait();
        return steady ? 0 : int'($urandom_range(0, 15));
    endfunction

    // result side
    always @(posedge clk)
    begin
        touch_word_t got;
        touch_word_t want;
        if (rst_n && result_bus.valid && result_bus.ready) begin
            got.kind = kind_t'(result_bus.kind);
            got.tx_byte = result_bus.tx_byte;
            got.status = status_t'(result_bus.status);
            got.screen_x = result_bus.screen_x;
            got.screen_y = result_bus.screen_y;
            got.raw_x = result_bus.raw_x;
            got.raw_y = result_bus.raw_y;
            got.raw_z1 = result_bus.raw_z1;
            got.raw_z2 = result_bus.raw_z2;
            if (expected_words.size() == 0) begin
                flag_mismatch("unexpected word", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
                    got.status !== want.status || got.screen_x !== want.screen_x ||
                    got.screen_y !== want.screen_y || got.raw_x !== want.raw_x ||
                    got.raw_y !== want.raw_y || got.raw_z1 !== want.raw_z1 ||
                    got.raw_z2 !== want.raw_z2)
                    flag_mismatch("word mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        int n;
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
            hold_cycles <= 0;
        end else if (result_bus.valid && result_bus.ready) begin
            n = draw_wait();
            hold_cycles <= n;
            result_bus.ready <= (n == 0);
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            result_bus.ready <= (hold_cycles == 1);
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
            idle_cycles <= 0;
        end else if (rst_n) begin
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_word(input action_t act, input logic [7:0] rx, input logic fail);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.action <= act;
        item_bus.rx_byte <= rx;
        item_bus.transfer_failed <= fail;
        do @(posedge clk); while (!item_bus.ready);
        advance_reader(act, rx, fail);
    endtask

    task automatic send_exchange(input logic [15:0] raw, input logic [7:0] echo);
        send_word(ACT_XFER, echo, 1'b0);
        send_word(ACT_XFER, raw[15:8], 1'b0);
        send_word(ACT_XFER, raw[7:0], 1'b0);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        send_exchange({s, 4'($urandom)}, 8'($urandom));
    endtask

    function automatic logic [SAMPLE_W-1:0] near(input logic [SAMPLE_W-1:0] c, input int j);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * j)) - j;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_in(input logic [SAMPLE_W-1:0] lo, hi);
        if (lo <= hi) return SAMPLE_W'($urandom_range(hi, lo));
        return SAMPLE_W'($urandom_range(lo, hi));
    endfunction

    task automatic take_reading(input logic [SAMPLE_W-1:0] z1, z2, xc, yc, input int jitter);
        send_word(ACT_START, 8'($urandom), 1'($urandom));
        send_sample(z1);
        send_sample(z2);
        repeat (SAMPLES_AVERAGED) send_sample(near(xc, jitter));
        repeat (SAMPLES_AVERAGED) send_sample(near(yc, jitter));
    endtask

    task automatic random_reading();
        int                  pick;
        int                  k;
        logic [SAMPLE_W-1:0] z1;
        logic [SAMPLE_W-1:0] xc;
        logic [SAMPLE_W-1:0] yc;
        steady = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 19);
        if (pick == 0 && !reading_active)
            repeat ($urandom_range(1, 3)) send_word(ACT_XFER, 8'($urandom), 1'($urandom));
        if (pick >= 1 && pick <= 3) begin
            send_word(ACT_START, 8'($urandom), 1'($urandom));
            k = $urandom_range(0, 3 * TOTAL_READS - 1);
            repeat (k) send_word(ACT_XFER, 8'($urandom), 1'b0);
            if (pick != 3) send_word(ACT_XFER, 8'($urandom), 1'b1);
        end
        if (pick == 1 || pick == 2) return;
        if ($urandom_range(0, 7) == 0 && cal_threshold != 0)
            z1 = SAMPLE_W'($urandom_range(cal_threshold - 1, 0));
        else
            z1 = SAMPLE_W'($urandom_range(4095, cal_threshold));
        xc = ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom) : pick_in(cal_x_min, cal_x_max);
        yc = ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom) : pick_in(cal_y_min, cal_y_max);
        take_reading(z1, SAMPLE_W'($urandom), xc, yc, $urandom_range(0, 6));
    endtask

    task automatic settle();
        if (reading_active) send_word(ACT_XFER, 8'($urandom), 1'b1);
        item_bus.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        case (idx)
            REG_THRESHOLD: cal_threshold = v;
            REG_X_MIN:     cal_x_min = v;
            REG_X_MAX:     cal_x_max = v;
            REG_Y_MIN:     cal_y_min = v;
            REG_Y_MAX:     cal_y_max = v;
            REG_X_SPAN:    cal_x_span = v[SPAN_W-1:0];
            REG_Y_SPAN:    cal_y_span = v[SPAN_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic load_calibration(input logic [SAMPLE_W-1:0] t, xl, xh, yl, yh,
                                    input logic [SPAN_W-1:0] xs, ys);
        write_reg(REG_THRESHOLD, t);
        write_reg(REG_X_MIN, xl);
        write_reg(REG_X_MAX, xh);
        write_reg(REG_Y_MIN, yl);
        write_reg(REG_Y_MAX, yh);
        write_reg(REG_X_SPAN, {2'($urandom), xs});
        write_reg(REG_Y_SPAN, {2'($urandom), ys});
        write_reg(REG_UNUSED, 12'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic exercise_calibration(input logic [SAMPLE_W-1:0] t, xl, xh, yl, yh,
                                        input logic [SPAN_W-1:0] xs, ys);
        load_calibration(t, xl, xh, yl, yh, xs, ys);
        repeat (READINGS_PER_SETTING) random_reading();
        settle();
    endtask

    task automatic test_ignored_and_failed_transfers();
        steady = 1'b0;
        send_word(ACT_XFER, 8'hFF, 1'b1);
        send_word(ACT_XFER, 8'h00, 1'b0);
        send_word(ACT_START, 8'h00, 1'b0);
        send_word(ACT_XFER, 8'hA5, 1'b1);
        settle();
    endtask

    task automatic test_restart_while_busy();
        send_word(ACT_START, 8'h5A, 1'b0);
        repeat (4) send_word(ACT_XFER, 8'($urandom), 1'b0);
        send_word(ACT_START, 8'hFF, 1'b1);
        // every sample at full scale: outside the default window
        repeat (TOTAL_READS) send_exchange(16'hFFFF, 8'hFF);
        settle();
    endtask

    task automatic test_zero_samples();
        steady = 1'b1;
        send_word(ACT_START, 8'h00, 1'b0);
        repeat (TOTAL_READS) send_exchange(16'h0000, 8'h00);
        settle();
    endtask

    task automatic test_default_calibration();
        repeat (8) random_reading();
        settle();
    endtask

    task automatic test_calibration_sweep();
        logic [SAMPLE_W-1:0] lo;
        // all zero: zero divisors, threshold never blocks
        exercise_calibration('0, '0, '0, '0, '0, '0, '0);
        exercise_calibration('1, '0, '1, '0, '1, '1, '1);
        // inverted windows
        exercise_calibration(SAMPLE_W'($urandom_range(0, 300)), 12'd3000, 12'd1000,
                             12'd2500, 12'd500, SPAN_W'($urandom), SPAN_W'($urandom));
        // single-point windows
        exercise_calibration(12'd100, 12'd2048, 12'd2048, 12'd777, 12'd777,
                             10'd511, 10'd600);
        repeat (2)
        begin
            lo = SAMPLE_W'($urandom_range(0, 2000));
            exercise_calibration(SAMPLE_W'($urandom_range(0, 600)), lo,
                                 SAMPLE_W'($urandom_range(4095, lo)),
                                 SAMPLE_W'($urandom_range(0, 1000)),
                                 SAMPLE_W'($urandom_range(4095, 1000)),
                                 SPAN_W'($urandom), SPAN_W'($urandom));
        end
        exercise_calibration(RST_THRESHOLD, RST_X_MIN, RST_X_MAX, RST_Y_MIN, RST_Y_MAX,
                             RST_X_SPAN, RST_Y_SPAN);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_bus.valid <= 1'b0;
        item_bus.action <= ACT_START;
        item_bus.rx_byte <= '0;
        item_bus.transfer_failed <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_THRESHOLD;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_ignored_and_failed_transfers();
        test_restart_while_busy();
        test_zero_samples();
        test_default_calibration();
        test_calibration_sweep();
        mismatches += expected_words.size();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
